// ===== design/ffpa_pkg.sv =====
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int NUM_PAGES_DEF   = 65536;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WAIT,
    S_SHIFT_WR,
    S_INS_RD,
    S_INS_WAIT,
    S_INS_WR,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ===== design/ffpa_ram.sv =====
`timescale 1ns / 1ps
module ffpa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/first_fit_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit page allocator over an address-ordered extent table in one RAM.
// A zero-count request, or a free that runs past the page space, goes straight to the
// result; otherwise table entries are examined in order, and a remove or insert
// then shifts the entries behind it before the result is given.
// Throughput: one request at a time; input is stalled until the result transfers.
// Reset (synchronous, rst high) empties the table and clears the free total
// and region base register; the table RAM itself is not cleared.
module first_fit_page_allocator_unit
  import ffpa_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int NUM_PAGES   = NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] first_page,
  input  logic [16:0] page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] page_index,
  output logic [16:0] free_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [17:0] LIMIT = (NUM_PAGES < 65536) ? 18'(NUM_PAGES) : 18'd65536;

  state_t state, state_next;

  logic [15:0] region_base;
  logic [16:0] region_len;
  logic [CW-1:0] count;
  logic [16:0] total;
  logic        req_mode;
  logic [15:0] req_base;
  logic [16:0] req_n;
  logic [CW-1:0] idx;
  logic [CW-1:0] dst;
  logic        have_prev;
  logic [15:0] prev_start;
  logic [16:0] prev_len;
  logic [1:0]  res_st;
  logic [15:0] res_idx;
  logic        shift_up;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [32:0]   wdata, rdata;
  logic [15:0]   r_start;
  logic [16:0]   r_len;

  ffpa_ram #(.WIDTH(33), .DEPTH(MAX_EXTENTS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_start = rdata[32:17];
  assign r_len   = rdata[16:0];

  // region length clipped to the page space
  always_comb begin
    if ({2'b0, region_base} >= LIMIT) begin
      region_len = '0;
    end else if ({1'b0, cfg_data} > LIMIT - {2'b0, region_base}) begin
      region_len = 17'(LIMIT - {2'b0, region_base});
    end else begin
      region_len = cfg_data;
    end
  end

  // shared compare datapath
  logic [17:0] req_end, prev_end;
  logic        at_end;
  assign req_end  = {2'b0, req_base} + {1'b0, req_n};
  assign prev_end = {2'b0, prev_start} + {1'b0, prev_len};
  assign at_end   = (idx == count);

  logic fit, past;
  assign fit  = (r_len >= req_n);
  assign past = ({2'b0, r_start} > {2'b0, req_base});

  logic join_lo, join_hi, ovl;
  assign join_lo = have_prev && (prev_end == {2'b0, req_base});
  assign join_hi = !at_end && ({2'b0, r_start} == req_end);
  assign ovl = (have_prev && (prev_end > {2'b0, req_base})) ||
               (!at_end && ({2'b0, r_start} < req_end));

  // a config transfer takes the idle cycle, so input waits
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status     = res_st;
  assign page_index = res_idx;
  assign free_total = total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !cfg_valid) begin
          if (page_count == 17'd0) state_next = S_OUT;
          else if (mode && ({2'b0, first_page} + {1'b0, page_count} > LIMIT))
            state_next = S_OUT;
          else state_next = S_RD;
        end
      end
      S_RD:   state_next = S_WAIT;
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        if (!req_mode) begin
          if (at_end) state_next = S_OUT;
          else if (fit) state_next = (r_len > req_n) ? S_OUT : S_SHIFT_RD;
          else state_next = S_RD;
        end else begin
          if (!at_end && !past) state_next = S_RD;
          else if (ovl) state_next = S_OUT;
          else if (join_lo && join_hi) state_next = S_SHIFT_RD;
          else if (join_lo || join_hi) state_next = S_OUT;
          else if (count == CW'(MAX_EXTENTS)) state_next = S_OUT;
          else state_next = S_INS_RD;
        end
      end
      S_SHIFT_RD:   state_next = (idx >= count) ? S_FIN : S_SHIFT_WAIT;
      S_SHIFT_WAIT: state_next = S_SHIFT_WR;
      S_SHIFT_WR:   state_next = S_SHIFT_RD;
      S_INS_RD:     state_next = (idx == dst) ? S_FIN : S_INS_WAIT;
      S_INS_WAIT:   state_next = S_INS_WR;
      S_INS_WR:     state_next = S_INS_RD;
      S_FIN:        state_next = S_OUT;
      S_OUT:        state_next = out_stall ? S_OUT : S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    we = 1'b0;
    waddr = AW'(idx);
    wdata = '0;
    raddr = AW'(idx);
    shift_up = 1'b0;
    unique case (state)
      S_IDLE: begin
        // region reload: the table becomes one extent, or empty for a zero-length region
        if (cfg_valid && cfg_index == CFG_PAGES) begin
          we = 1'b1;
          waddr = '0;
          wdata = {region_base, region_len};
        end
      end
      S_CHECK: begin
        if (!req_mode && !at_end && fit && (r_len > req_n)) begin
          we = 1'b1;
          wdata = {r_start + req_n[15:0], r_len - req_n};
        end else if (req_mode && !(!at_end && !past) && !ovl) begin
          if (join_lo) begin
            we = 1'b1;
            waddr = AW'(idx - CW'(1));
            wdata = {prev_start, prev_len + req_n + (join_hi ? r_len : 17'd0)};
          end else if (join_hi) begin
            we = 1'b1;
            wdata = {req_base, r_len + req_n};
          end
        end
      end
      S_SHIFT_RD: raddr = AW'(idx);
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = AW'(idx - CW'(1));
        wdata = rdata;
      end
      S_INS_RD:   raddr = AW'(idx - CW'(1));
      S_INS_WAIT: raddr = AW'(idx - CW'(1));
      S_INS_WR: begin
        we = 1'b1;
        waddr = AW'(idx);
        wdata = rdata;
        shift_up = 1'b1;
      end
      S_FIN: begin
        if (req_mode && !join_lo) begin
          we = 1'b1;
          waddr = AW'(dst);
          wdata = {req_base, req_n};
        end
      end
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      region_base <= '0;
      count <= '0;
      total <= '0;
      res_st <= ST_OK;
      res_idx <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_BASE) begin
              region_base <= cfg_data[15:0];
            end else begin
              total <= region_len;
              count <= (region_len == 17'd0) ? CW'(0) : CW'(1);
            end
          end
          if (in_valid && !cfg_valid) begin
            req_mode <= mode;
            req_base <= first_page;
            req_n <= page_count;
            idx <= '0;
            have_prev <= 1'b0;
            res_idx <= '0;
            res_st <= (page_count == 17'd0) ? ST_ZERO :
                      (mode && ({2'b0, first_page} + {1'b0, page_count} > LIMIT)) ?
                      ST_NOFIT : ST_OK;
          end
        end
        S_CHECK: begin
          if (!req_mode) begin
            if (at_end) res_st <= ST_NOFIT;
            else if (fit) begin
              res_idx <= r_start;
              total <= total - req_n;
              idx <= idx + CW'(1);
            end else idx <= idx + CW'(1);
          end else begin
            if (!at_end && !past) begin
              have_prev <= 1'b1;
              prev_start <= r_start;
              prev_len <= r_len;
              idx <= idx + CW'(1);
            end else if (ovl) res_st <= ST_NOFIT;
            else if (join_lo && join_hi) begin
              total <= total + req_n;
              idx <= idx + CW'(1);
            end else if (join_lo || join_hi) total <= total + req_n;
            else if (count == CW'(MAX_EXTENTS)) res_st <= ST_FULL;
            else begin
              total <= total + req_n;
              dst <= idx;
              idx <= count;
            end
          end
        end
        // remove shift starts one entry past the removed slot and copies down
        S_SHIFT_WR: idx <= idx + CW'(1);
        S_INS_WR: if (shift_up) idx <= idx - CW'(1);
        S_FIN: begin
          if (req_mode && !join_lo) count <= count + CW'(1);
          else count <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // join_lo stays valid in FIN since it depends only on the saved previous extent and the request
  // for a free: only a no-join insert reaches FIN with count growing

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(page_index))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS))
    else $error("extent count overflow");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> page_index == 16'd0)
    else $error("page index set on failure");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cfg_ready)
    else $error("config accepted while busy");

endmodule
